// ----- src/indexed_insert_list_top_assert.svh -----
// ----------------------------------------------------------------------------
// Indexed insert list assertion macros
// Shared property forms for the list checks, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_LIST_TOP_ASSERT_SVH
`define INDEXED_INSERT_LIST_TOP_ASSERT_SVH

// same-cycle implication
`define IIL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("indexed insert list: same-cycle check failed");

// next-cycle implication
`define IIL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("indexed insert list: next-cycle check failed");

`endif

// ----- src/iil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert list package
// Operation and status codes, and the control group sent to the cells.
// ----------------------------------------------------------------------------
package iil_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W = 5;
  localparam int POS2_W = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_READ   = 3'd2,
    FN_SWAP   = 3'd3,
    FN_POP    = 3'd4,
    FN_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic ins_en;
    logic swp_en;
  } cell_ctrl_t;

endpackage

// ----- src/indexed_insert_list_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert list top
// Fixed-capacity list of signed words held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a request transfers when start_i is high and busy_o is
//   low; busy_o stays low, so a request may be issued in every cycle.
//   Request fields: func_i, position_i, other_position_i, word_in_i.
//   Result channel: done_o pulses for one cycle with word_out_o,
//   entry_count_o and status_o, in the cycle after the request transfer.
//   Throughput 1 request per cycle: each request is decoded and all cells
//   update in the same cycle; insert shifts every cell from the index up
//   into its right neighbor at once.
//   Reset: count goes to zero, no result pending; stored words are not
//   cleared and read as valid only once written.
//   The receiver cannot stall; a result is gone after its done_o cycle.
//   entry_count_o shows the count modulo 32.
// ----------------------------------------------------------------------------
module indexed_insert_list_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         func_i,
  input  logic [4:0]         position_i,
  input  logic [3:0]         other_position_i,
  input  logic signed [31:0] word_in_i,
  output logic               done_o,
  output logic signed [31:0] word_out_o,
  output logic [4:0]         entry_count_o,
  output logic [1:0]         status_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > iil_pkg::POS_W) ? CW : iil_pkg::POS_W;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [CW-1:0] count_q, count_d;
  logic done_q;
  logic [iil_pkg::WORD_W-1:0] rd_q, rd_d;
  logic [iil_pkg::CNT_OUT_W-1:0] cnt_out_q;
  iil_pkg::status_e st_q, st_d;

  iil_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0] ins_idx, swp_a, swp_b;
  logic [iil_pkg::WORD_W-1:0] va, vb;
  logic [iil_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic [XW-1:0] ext_cnt, ext_pos, ext_pos2;
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign ext_cnt = XW'(count_q);
  assign ext_pos = XW'(position_i);
  assign ext_pos2 = XW'(other_position_i);
  assign swp_a = CW'(position_i);
  assign swp_b = CW'(other_position_i);

  always_comb begin
    va = '0;
    vb = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (swp_a == CW'(i)) va = cell_data[i];
      if (swp_b == CW'(i)) vb = cell_data[i];
    end
  end

  always_comb begin
    ctrl = '0;
    ins_idx = CW'(position_i);
    count_d = count_q;
    rd_d = '0;
    st_d = iil_pkg::ST_OK;
    if (accept) begin
      case (iil_pkg::func_e'(func_i))
        iil_pkg::FN_APPEND: begin
          ins_idx = count_q;
          if (count_q == Full) begin
            st_d = iil_pkg::ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        iil_pkg::FN_INSERT: begin
          if (ext_pos > ext_cnt) begin
            st_d = iil_pkg::ST_RANGE;
          end else if (count_q == Full) begin
            st_d = iil_pkg::ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        iil_pkg::FN_READ: begin
          if (ext_pos >= ext_cnt) begin
            st_d = iil_pkg::ST_RANGE;
          end else begin
            rd_d = va;
          end
        end
        iil_pkg::FN_SWAP: begin
          if (ext_pos >= ext_cnt || ext_pos2 >= ext_cnt) begin
            st_d = iil_pkg::ST_RANGE;
          end else begin
            ctrl.swp_en = 1'b1;
          end
        end
        iil_pkg::FN_POP: begin
          if (count_q == '0) begin
            st_d = iil_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        iil_pkg::FN_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [iil_pkg::WORD_W-1:0] left;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = cell_data[g-1];
    end
    iil_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .ins_idx_i (ins_idx),
      .swp_a_i   (swp_a),
      .swp_b_i   (swp_b),
      .word_i    (word_in_i),
      .left_i    (left),
      .va_i      (va),
      .vb_i      (vb),
      .data_o    (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
    st_q <= st_d;
    cnt_out_q <= iil_pkg::CNT_OUT_W'(count_d);
  end

  assign done_o = done_q;
  assign word_out_o = rd_q;
  assign entry_count_o = cnt_out_q;
  assign status_o = st_q;

`include "indexed_insert_list_top_assert.svh"

  `IIL_ASSERT_NEXT(a_done_follows, start_i && !busy_o, done_o)
  `IIL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= Full)
  `IIL_ASSERT_NOW(a_full_count, done_o && status_o == iil_pkg::ST_FULL, count_q == Full)
  `IIL_ASSERT_NOW(a_empty_count, done_o && status_o == iil_pkg::ST_EMPTY, count_q == '0)

endmodule

// ----- src/iil_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert list cell
// Holds one entry; takes the word, its left neighbor or a swap partner.
// ----------------------------------------------------------------------------
module iil_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                       clk_i,
  input  iil_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]              ins_idx_i,
  input  logic [CW-1:0]              swp_a_i,
  input  logic [CW-1:0]              swp_b_i,
  input  logic [iil_pkg::WORD_W-1:0] word_i,
  input  logic [iil_pkg::WORD_W-1:0] left_i,
  input  logic [iil_pkg::WORD_W-1:0] va_i,
  input  logic [iil_pkg::WORD_W-1:0] vb_i,
  output logic [iil_pkg::WORD_W-1:0] data_o
);

  localparam logic [CW-1:0] OwnIdx = CW'(IDX);

  logic [iil_pkg::WORD_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (OwnIdx == ins_idx_i) begin
        entry_d = word_i;
      end else if (OwnIdx > ins_idx_i) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.swp_en) begin
      if (OwnIdx == swp_a_i) begin
        entry_d = vb_i;
      end else if (OwnIdx == swp_b_i) begin
        entry_d = va_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;

endmodule
